// File: hdl/assert_macros.svh
// Assertion macros used by the port checks in hdl/sts_checker.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held
`define STS_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, off while reset is held
`define STS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// Checks the cycle after a reset edge
`define STS_ASSERT_RESET(lbl, post, msg) \
  lbl: assert property (@(posedge clk) (!rst_n) |=> (post)) \
    else $error(msg);

`endif

// File: hdl/sts_pkg.sv
// Constants and word types for the spectral threshold scaler
package sts_pkg;

  localparam int FFT_SIZE   = 1024;
  localparam int NUM_BINS   = FFT_SIZE / 2 + 1;
  localparam int BIN_AW     = $clog2(NUM_BINS);
  localparam int BIN_NUM_W  = 10;
  localparam int MAG_W      = 32;
  localparam int GAIN_W     = 24;
  localparam int THR_W      = 24;
  localparam int HZ_W       = 16;
  localparam int SPC_W      = 24;
  localparam int F_W        = BIN_AW + SPC_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int DIV_STEPS  = THR_W;
  localparam int DIV_CW     = $clog2(DIV_STEPS);

  localparam logic [MAG_W-1:0] ONE_Q16 = 32'h0001_0000;

  // Register reset values
  localparam logic [HZ_W-1:0]  KNEE_RST   = 16'd1000;
  localparam logic [HZ_W-1:0]  CUTOFF_RST = 16'd4000;
  localparam logic [THR_W-1:0] LOW_RST    = 24'd1678;
  localparam logic [THR_W-1:0] HIGH_RST   = 24'd1509949;
  localparam logic [SPC_W-1:0] SPC_RST    = 24'd11025;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KNEE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 3'd4;

  typedef struct packed {
    logic        [MAG_W-1:0]  magnitude;
    logic signed [GAIN_W-1:0] multiplier;
  } in_word_t;

  typedef struct packed {
    logic signed [MAG_W-1:0]     magnitude_out;
    logic        [BIN_NUM_W-1:0] bin_number;
    logic                        last_bin;
  } out_word_t;

endpackage

// File: hdl/spectral_threshold_scaler_core.sv
// Spectral threshold scaler: frame store, threshold ramp and weak-bin gain
//
// Usage notes:
// - in_*: one word per bin, bins 0 to FFT_SIZE/2 in order. multiplier is
//   only sampled on bin 0 and applies to that frame when it is replayed.
// - out_*: each input word answers with the same bin of the previous frame,
//   processed. The first frame after reset gives no output words.
// - cfg_*: write-only register port, one write per cycle when cfg_we is high.
//   Only write while the block is idle.
// - Occupancy: a bin with output due keeps in_ready low from acceptance
//   through FREQ, CLASS, MUL and OUT; bins whose frequency lies in the
//   ramp also pass LOAD, the one-bit-per-cycle restoring divider (24 steps)
//   and RAMP. First-frame words are taken without leaving S_IDLE.
// - Result path: loaded into out_* from S_OUT once the output register is free.
// - A finished word waits in the output register; the next input word is
//   taken meanwhile, but its result holds in the last stage until the
//   receiver takes the waiting one.
// - Reset (synchronous, rst_n low) restores the register defaults, the peak
//   of 1.0 and the bin counter. The frame store itself is not cleared;
//   the first-frame gate keeps unwritten entries from ever being used.
module spectral_threshold_scaler_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sts_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sts_pkg::out_word_t                  out_data,
  input  logic                                cfg_we,
  input  logic [sts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sts_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int BIN_AW = sts_pkg::BIN_AW;
  localparam int MAG_W  = sts_pkg::MAG_W;
  localparam int GAIN_W = sts_pkg::GAIN_W;
  localparam int THR_W  = sts_pkg::THR_W;
  localparam int F_W    = sts_pkg::F_W;
  localparam int TP_W   = THR_W + MAG_W;
  localparam int SP_W   = MAG_W + 1 + GAIN_W;
  localparam int PR_W   = 2 * THR_W;

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FREQ  = 3'd1;
  localparam logic [2:0] S_CLASS = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_RAMP  = 3'd5;
  localparam logic [2:0] S_MUL   = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  localparam logic [BIN_AW-1:0] LAST_BIN = BIN_AW'(sts_pkg::NUM_BINS - 1);

  // Configuration registers
  logic [sts_pkg::HZ_W-1:0]  knee_r, cutoff_r;
  logic [THR_W-1:0]          low_r, high_r;
  logic [sts_pkg::SPC_W-1:0] spacing_r;

  // Frame-level state
  logic [2:0]        state_r;
  logic [BIN_AW-1:0] bin_cnt_r;
  logic              frame_seen_r;
  logic [MAG_W-1:0]  running_peak_r, frame_peak_r;
  logic [GAIN_W-1:0] latched_gain_r, active_gain_r;

  // Per-bin job registers
  logic [BIN_AW-1:0]        job_bin_r;
  logic                     job_last_r;
  logic [MAG_W-1:0]         job_peak_r;
  logic signed [GAIN_W-1:0] job_gain_r;
  logic [MAG_W-1:0]         rd_data_r;
  logic [MAG_W-1:0]         job_mag_r;
  logic [F_W-1:0]           f_r;
  logic [THR_W-1:0]         thr_r, den_r, rem_r, quo_r;
  logic                     neg_r;
  logic [PR_W-1:0]          prod_r;
  logic [sts_pkg::DIV_CW-1:0] div_cnt_r;
  logic [TP_W-1:0]          tp_r;
  logic signed [SP_W-1:0]   sp_r;
  logic                     out_valid_r;
  sts_pkg::out_word_t       out_data_r;

  // Frame store: single-port, read-first. Each bin reads the old frame's
  // entry and writes the new one at the same edge, so accesses never overlap.
  logic [MAG_W-1:0] frame_mem [sts_pkg::NUM_BINS];

  logic accept;
  logic last_cur;
  logic out_load;
  logic [MAG_W-1:0]  peak_nxt;
  logic [GAIN_W-1:0] latched_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign last_cur  = (bin_cnt_r == LAST_BIN);
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign peak_nxt    = (in_data.magnitude > running_peak_r) ? in_data.magnitude
                                                            : running_peak_r;
  assign latched_nxt = (bin_cnt_r == '0) ? in_data.multiplier : latched_gain_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r                <= frame_mem[bin_cnt_r];
      frame_mem[bin_cnt_r]     <= in_data.magnitude;
    end
  end

  // Datapath next values
  logic [BIN_AW-1:0]       bin_inc;
  logic [F_W-1:0]          f_nxt, kq_ext, cq_ext;
  logic [THR_W-1:0]        kq, cq, fk, abs_diff, den_nxt;
  logic signed [THR_W:0]   diff_s;
  logic [PR_W-1:0]         prod_nxt;
  logic [THR_W:0]          r2, rdiff;
  logic                    div_ge;
  logic [THR_W-1:0]        rem_nxt, thr_ramp;
  logic [TP_W-1:0]         tp_nxt;
  logic signed [SP_W-1:0]  sp_nxt;
  logic                    is_weak;
  logic [MAG_W-1:0]        scaled_sat, pass_sat, mag_res;
  logic                    sp_ovf;

  always_comb begin
    bin_inc  = job_bin_r + BIN_AW'(1);
    f_nxt    = F_W'(bin_inc) * F_W'(spacing_r);
    kq       = {knee_r, 8'h00};
    cq       = {cutoff_r, 8'h00};
    kq_ext   = F_W'(kq);
    cq_ext   = F_W'(cq);
    diff_s   = $signed({1'b0, high_r}) - $signed({1'b0, low_r});
    abs_diff = diff_s[THR_W] ? THR_W'(-diff_s) : diff_s[THR_W-1:0];
    // f lies below cutoff here, so the offset fits the threshold width
    fk       = THR_W'(f_r - kq_ext);
    den_nxt  = cq - kq;
    prod_nxt = PR_W'(abs_diff) * PR_W'(fk);

    // Restoring divider step: dividend bits shift out of quo_r's top
    r2       = {rem_r, quo_r[THR_W-1]};
    rdiff    = r2 - {1'b0, den_r};
    div_ge   = (r2 >= {1'b0, den_r});
    rem_nxt  = div_ge ? rdiff[THR_W-1:0] : r2[THR_W-1:0];
    thr_ramp = neg_r ? (low_r - quo_r) : (low_r + quo_r);

    tp_nxt   = TP_W'(thr_r) * TP_W'(job_peak_r);
    sp_nxt   = $signed({1'b0, job_mag_r}) * job_gain_r;

    // Floor shift by 16 then clamp to signed 32 bits
    is_weak    = {job_mag_r, 24'h000000} < tp_r;
    sp_ovf     = (sp_r[SP_W-1:MAG_W+15] != {(SP_W-MAG_W-15){sp_r[MAG_W+15]}});
    scaled_sat = sp_ovf ? (sp_r[SP_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                        : sp_r[MAG_W+15:16];
    pass_sat   = job_mag_r[MAG_W-1] ? 32'h7FFF_FFFF : job_mag_r;
    mag_res    = is_weak ? scaled_sat : pass_sat;
  end

  // Control and frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      knee_r         <= sts_pkg::KNEE_RST;
      cutoff_r       <= sts_pkg::CUTOFF_RST;
      low_r          <= sts_pkg::LOW_RST;
      high_r         <= sts_pkg::HIGH_RST;
      spacing_r      <= sts_pkg::SPC_RST;
      state_r        <= S_IDLE;
      bin_cnt_r      <= '0;
      frame_seen_r   <= 1'b0;
      running_peak_r <= sts_pkg::ONE_Q16;
      frame_peak_r   <= sts_pkg::ONE_Q16;
      latched_gain_r <= '0;
      active_gain_r  <= '0;
      out_valid_r    <= 1'b0;
      div_cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sts_pkg::CFG_KNEE:    knee_r    <= cfg_wdata[sts_pkg::HZ_W-1:0];
          sts_pkg::CFG_CUTOFF:  cutoff_r  <= cfg_wdata[sts_pkg::HZ_W-1:0];
          sts_pkg::CFG_LOW:     low_r     <= cfg_wdata[THR_W-1:0];
          sts_pkg::CFG_HIGH:    high_r    <= cfg_wdata[THR_W-1:0];
          sts_pkg::CFG_SPACING: spacing_r <= cfg_wdata[sts_pkg::SPC_W-1:0];
          default: ;
        endcase
      end

      // Output register: load a finished word, else clear once taken
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            latched_gain_r <= latched_nxt;
            if (last_cur) begin
              frame_peak_r   <= peak_nxt;
              running_peak_r <= sts_pkg::ONE_Q16;
              active_gain_r  <= latched_nxt;
              frame_seen_r   <= 1'b1;
              bin_cnt_r      <= '0;
            end else begin
              running_peak_r <= peak_nxt;
              bin_cnt_r      <= bin_cnt_r + BIN_AW'(1);
            end
            if (frame_seen_r) begin
              state_r <= S_FREQ;
            end
          end
        end
        S_FREQ: begin
          state_r <= S_CLASS;
        end
        S_CLASS: begin
          if (f_r >= kq_ext && f_r < cq_ext) begin
            state_r <= S_LOAD;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_LOAD: begin
          div_cnt_r <= '0;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          if (div_cnt_r == sts_pkg::DIV_CW'(sts_pkg::DIV_STEPS - 1)) begin
            state_r <= S_RAMP;
          end else begin
            div_cnt_r <= div_cnt_r + sts_pkg::DIV_CW'(1);
          end
        end
        S_RAMP: begin
          state_r <= S_MUL;
        end
        S_MUL: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          job_bin_r  <= bin_cnt_r;
          job_last_r <= last_cur;
          job_peak_r <= frame_peak_r;
          job_gain_r <= active_gain_r;
        end
      end
      S_FREQ: begin
        f_r       <= f_nxt;
        job_mag_r <= rd_data_r;
      end
      S_CLASS: begin
        thr_r    <= (f_r < kq_ext) ? '0 : high_r;
        prod_r   <= prod_nxt;
        den_r    <= den_nxt;
        neg_r    <= diff_s[THR_W];
      end
      S_LOAD: begin
        // Quotient stays below |high - low|, so the top half is below den
        rem_r <= prod_r[PR_W-1:THR_W];
        quo_r <= prod_r[THR_W-1:0];
      end
      S_DIV: begin
        rem_r <= rem_nxt;
        quo_r <= {quo_r[THR_W-2:0], div_ge};
      end
      S_RAMP: begin
        thr_r <= thr_ramp;
      end
      S_MUL: begin
        tp_r <= tp_nxt;
        sp_r <= sp_nxt;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_data_r.magnitude_out <= mag_res;
          out_data_r.bin_number    <= sts_pkg::BIN_NUM_W'(job_bin_r);
          out_data_r.last_bin      <= job_last_r;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: hdl/sts_checker.sv
// Port-level checks for the spectral threshold scaler, bound to the core
`include "assert_macros.svh"

module sts_port_checks (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input sts_pkg::out_word_t out_data
);

  `STS_ASSERT_RESET(a_reset_clears_out, !out_valid, "output word valid after reset")
  `STS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data),
    "stalled output word dropped or changed")
  `STS_ASSERT_IMPL(a_bin_range, out_valid,
    out_data.bin_number <= sts_pkg::BIN_NUM_W'(sts_pkg::NUM_BINS - 1),
    "output bin number beyond the top bin")
  `STS_ASSERT_IMPL(a_last_flag, out_valid,
    out_data.last_bin == (out_data.bin_number == sts_pkg::BIN_NUM_W'(sts_pkg::NUM_BINS - 1)),
    "last bin flag disagrees with bin number")

endmodule

bind spectral_threshold_scaler_core sts_port_checks u_sts_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: test/sts_checker.sv
// Scoreboard for the spectral threshold scaler: predicts every output word and compares it
`timescale 1ns / 100ps

module sts_checker
  import sts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_word_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned           mismatches,
  output int unsigned           pending
);

  localparam int     REPORT_LIMIT = 10;
  localparam longint SAT_MAX      = 64'sd2147483647;
  localparam longint SAT_MIN      = -64'sd2147483648;

  // Shadow registers
  logic [HZ_W-1:0]  knee_q;
  logic [HZ_W-1:0]  cutoff_q;
  logic [THR_W-1:0] thr_lo;
  logic [THR_W-1:0] thr_hi;
  logic [SPC_W-1:0] spacing_q;

  // Shadow state of the frame pipeline
  logic [MAG_W-1:0]  frame_mem [NUM_BINS];
  logic [MAG_W-1:0]  peak_run;
  logic [MAG_W-1:0]  peak_frame;
  logic [GAIN_W-1:0] gain_next;
  logic [GAIN_W-1:0] gain_used;
  int unsigned       bin_pos;
  bit                replaying;

  out_word_t   due_words [$];
  int unsigned fail_total;

  // Threshold of a bin as a Q0.24 fraction of the peak
  function automatic logic [63:0] ramp_threshold(int unsigned bin);
    logic [63:0] f;
    logic [63:0] kq;
    logic [63:0] cq;
    longint      lo_s;
    longint      hi_s;
    longint      num;
    longint      den;
    f    = 64'(bin + 1) * 64'(spacing_q);
    kq   = 64'(knee_q) << 8;
    cq   = 64'(cutoff_q) << 8;
    lo_s = thr_lo;
    hi_s = thr_hi;
    if (f < kq) return '0;
    if (f < cq) begin
      num = (hi_s - lo_s) * longint'(f - kq);
      den = longint'(cq - kq);
      return 64'(lo_s + num / den);
    end
    return 64'(thr_hi);
  endfunction

  function automatic logic [MAG_W-1:0] shaped_magnitude(int unsigned bin,
                                                        logic [MAG_W-1:0] mag);
    logic [63:0] level;
    logic [63:0] bar;
    longint      prod;
    longint      scaled;
    level = 64'(mag) << 24;
    bar   = ramp_threshold(bin) * 64'(peak_frame);
    if (level < bar) begin
      prod   = longint'(mag) * longint'($signed(gain_used));
      scaled = prod >>> 16;
      if (scaled > SAT_MAX) return 32'h7FFF_FFFF;
      if (scaled < SAT_MIN) return 32'h8000_0000;
      return scaled[31:0];
    end
    return (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
  endfunction

  always @(posedge clk) begin : track
    out_word_t   got;
    out_word_t   want;
    int unsigned bin;
    logic        last;
    if (!rst_n) begin
      knee_q     = KNEE_RST;
      cutoff_q   = CUTOFF_RST;
      thr_lo     = LOW_RST;
      thr_hi     = HIGH_RST;
      spacing_q  = SPC_RST;
      peak_run   = ONE_Q16;
      peak_frame = ONE_Q16;
      gain_next  = '0;
      gain_used  = '0;
      bin_pos    = 0;
      replaying  = 1'b0;
      fail_total = 0;
      due_words.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_KNEE:    knee_q    = cfg_wdata[HZ_W-1:0];
          CFG_CUTOFF:  cutoff_q  = cfg_wdata[HZ_W-1:0];
          CFG_LOW:     thr_lo    = cfg_wdata[THR_W-1:0];
          CFG_HIGH:    thr_hi    = cfg_wdata[THR_W-1:0];
          CFG_SPACING: spacing_q = cfg_wdata[SPC_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        got = out_data;
        if (due_words.size() == 0) begin
          fail_total++;
          if (fail_total <= REPORT_LIMIT)
            $display("unexpected output word: mag %0d bin %0d last %0b",
                     got.magnitude_out, got.bin_number, got.last_bin);
        end else begin
          want = due_words.pop_front();
          if (got !== want) begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
              $display("mismatch: expected mag %0d bin %0d last %0b, got mag %0d bin %0d last %0b",
                       want.magnitude_out, want.bin_number, want.last_bin,
                       got.magnitude_out, got.bin_number, got.last_bin);
          end
        end
      end

      if (in_valid && in_ready) begin
        bin  = (bin_pos >= NUM_BINS) ? 0 : bin_pos;
        last = (bin == NUM_BINS - 1);
        if (bin == 0) gain_next = in_data.multiplier;
        if (replaying) begin
          want.magnitude_out = shaped_magnitude(bin, frame_mem[bin]);
          want.bin_number    = BIN_NUM_W'(bin);
          want.last_bin      = last;
          due_words.push_back(want);
        end
        frame_mem[bin] = in_data.magnitude;
        if (in_data.magnitude > peak_run) peak_run = in_data.magnitude;
        if (last) begin
          peak_frame = peak_run;
          peak_run   = ONE_Q16;
          gain_used  = gain_next;
          replaying  = 1'b1;
          bin_pos    = 0;
        end else begin
          bin_pos = bin + 1;
        end
      end
    end
    mismatches <= fail_total;
    pending    <= due_words.size();
  end

endmodule

// File: test/spectral_threshold_scaler_core_tb.sv
// Top of the spectral threshold scaler test: clock, reset, stimulus, receiver and verdict
`timescale 1ns / 100ps

module spectral_threshold_scaler_core_tb;
  import sts_pkg::*;

  // Run shape: frame 0 fills the store and is replayed bin by bin during frame 1.
  // Once replay is under way the register setting changes every PHASE_LEN words.
  localparam int ITEM_TOTAL    = 900;
  localparam int PHASE_LEN     = 50;
  localparam int DIRECTED_N    = 12;
  // Extra idle margin after the drain, before the next register writes
  localparam int SETTLE_CYCLES = 40;
  // Long receiver hold-off, so the block backs up onto its input
  localparam int HOLD_CYCLES   = 600;
  // Cycles without any handshake before the run is declared stuck
  localparam int STALL_LIMIT   = 5000;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_word_t         in_data;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_word_t        out_data;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned words_out = 0;
  int unsigned quiet_cycles = 0;

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  spectral_threshold_scaler_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  sts_checker bin_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Opening words of frame 0: field extremes and values round 1.0.
  // Bin 0 carries the most negative gain, so the larger weak bins of frame 0 saturate low.
  function automatic in_word_t directed_word(int unsigned k);
    in_word_t w;
    case (k)
      0:       w = '{magnitude: 32'hFFFF_FFFF, multiplier: 24'sh80_0000};
      1:       w = '{magnitude: 32'h0000_0000, multiplier: 24'sh7F_FFFF};
      2:       w = '{magnitude: 32'h7FFF_FFFF, multiplier: 24'shFF_FFFF};
      3:       w = '{magnitude: 32'h8000_0000, multiplier: 24'sh00_0000};
      4:       w = '{magnitude: ONE_Q16,       multiplier: 24'sh00_0001};
      5:       w = '{magnitude: ONE_Q16 - 1,   multiplier: 24'sh01_0000};
      6:       w = '{magnitude: 32'h0000_0001, multiplier: 24'shAA_AAAA};
      7:       w = '{magnitude: 32'h00FF_FFFF, multiplier: 24'sh55_5555};
      8:       w = '{magnitude: 32'h0000_0100, multiplier: 24'shFF_0000};
      9:       w = '{magnitude: 32'h0800_0000, multiplier: 24'sh00_FFFF};
      10:      w = '{magnitude: 32'h7FFF_0000, multiplier: 24'sh80_0001};
      default: w = '{magnitude: 32'h0000_8000, multiplier: 24'sh7F_FFFE};
    endcase
    return w;
  endfunction

  // Log-spread magnitudes give a mix of weak and strong bins against the peak.
  // Frame 2 stays below 1.0 so its peak falls back to the 1.0 floor.
  function automatic logic [MAG_W-1:0] pick_magnitude(int unsigned frame);
    int unsigned sel;
    if (frame == 2) return $urandom() >> $urandom_range(16, 31);
    sel = $urandom_range(0, 19);
    if (sel == 0) return 32'h0000_0000;
    if (sel == 1) return 32'hFFFF_FFFF;
    if (sel == 2) return 32'h7FFF_FFFF;
    if (sel == 3) return 32'h8000_0000;
    return $urandom() >> $urandom_range(0, 31);
  endfunction

  function automatic in_word_t random_word(int unsigned k);
    in_word_t    w;
    int unsigned bin;
    int unsigned frame;
    bin   = k % NUM_BINS;
    frame = k / NUM_BINS;
    w.magnitude  = pick_magnitude(frame);
    w.multiplier = 24'($urandom());
    // gain only counts at bin 0; frame 1 takes the largest one
    if (bin == 0 && frame == 1) w.multiplier = 24'sh7F_FFFF;
    return w;
  endfunction

  // Offer one word and return at the edge that takes it
  task automatic push_word(input in_word_t w);
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_cycles(input int unsigned n);
    in_valid <= 1'b0;
    in_data  <= in_word_t'({$urandom(), 24'($urandom())});
    repeat (n) @(posedge clk);
  endtask

  // Stop sending, drain every due word, then wait out the settle margin
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // Register setting for each phase; phase 0 runs on the reset values
  task automatic load_config(input int unsigned phase);
    logic [CFG_DATA_W-1:0] knee;
    logic [CFG_DATA_W-1:0] cutoff;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    logic [CFG_DATA_W-1:0] spacing;
    lo = 24'($urandom());
    hi = 24'($urandom());
    case (phase)
      1: begin
        // every bin inside the ramp, which falls from full scale to zero
        knee = 24'd0; cutoff = 24'd65535; lo = 24'hFF_FFFF; hi = 24'd0; spacing = 24'd1;
      end
      2: begin
        // cutoff below knee, widest spacing: all bins take the high threshold
        knee = 24'd65535; cutoff = 24'd1; hi = 24'hFF_FFFF; spacing = 24'hFF_FFFF;
      end
      3: begin
        // zero spacing: every bin sits below the knee
        knee = 24'd500; cutoff = 24'd4000; spacing = 24'd0;
      end
      4: begin
        // knee equal to cutoff, no ramp
        knee = 24'd2000; cutoff = 24'd2000; spacing = 24'd11025;
      end
      5: begin
        // full-width writes; the hertz registers keep their low 16 bits
        knee    = 24'($urandom());
        cutoff  = {8'($urandom()), 16'($urandom_range(1, 65535))};
        spacing = 24'($urandom_range(1, 24'hFF_FFFF));
      end
      6: begin
        knee    = 24'(KNEE_RST);
        cutoff  = 24'(CUTOFF_RST);
        lo      = LOW_RST;
        hi      = HIGH_RST;
        spacing = SPC_RST;
      end
      default: begin
        // ramp across a good share of the bins, either direction
        knee    = 24'($urandom_range(0, 8000));
        cutoff  = knee + 24'($urandom_range(1, 20000));
        spacing = 24'($urandom_range(256, 16384));
      end
    endcase
    write_reg(CFG_KNEE, knee);
    write_reg(CFG_CUTOFF, cutoff);
    write_reg(CFG_LOW, lo);
    write_reg(CFG_HIGH, hi);
    write_reg(CFG_SPACING, spacing);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length with random gaps, long gap-free runs now and then
  // ---------------------------------------------------------------------------
  initial begin : sender
    int unsigned k;
    int unsigned burst_left;
    int unsigned gap;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    burst_left = $urandom_range(1, 40);
    for (k = 0; k < ITEM_TOTAL; k++) begin
      // new register setting only once the block has gone quiet
      if (k > NUM_BINS && (k - NUM_BINS) % PHASE_LEN == 0) begin
        settle();
        load_config((k - NUM_BINS) / PHASE_LEN);
      end
      push_word((k < DIRECTED_N) ? directed_word(k) : random_word(k));
      burst_left--;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap != 0) idle_cycles(gap);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(1, 40);
      end
    end

    settle();
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready runs and short stalls of random length, plus one long hold
  // taken while the sender is offering, once results are flowing
  // ---------------------------------------------------------------------------
  int unsigned ready_left = 0;
  int unsigned stall_left = 0;
  int unsigned hold_left  = 0;
  bit          hold_done  = 1'b0;

  always @(posedge clk) begin
    if (!hold_done && words_out >= 150 && in_valid) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (ready_left > 0) begin
      ready_left--;
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      stall_left = $urandom_range(0, 7);
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Word count for the receiver, and the watchdog on handshake-free cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) words_out <= words_out + 1;
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

endmodule
